[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/swa_pkg.sv]
package swa_pkg;

    // Window size register
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd4;

    // Defaults for the top-level parameters
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

endpackage

[hdl/sliding_window_average.sv]
// Moving average over the newest window_size samples, one result per item once full.
// An accepted item goes through the update, sign, divide and done states to the
// result register; the restoring divider retires one quotient bit per cycle over
// SUM_W = 38 bits by default. No new sample is taken until the last one is through;
// once full, the input stalls until the divider is done and the result register is free.
// Reset (synchronous, active low) empties the window and sets window_size to 4.
`include "assert_macros.svh"

module sliding_window_average import swa_pkg::*; #(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    // average channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_average,
    // window size register
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_W-1:0]               i_cfg_window_size
);

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int N_MAX   = (WINDOW_MAX < CFG_MAX) ? WINDOW_MAX : CFG_MAX;
    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W   = SAMPLE_WIDTH + $clog2(N_MAX);
    localparam int CNT_W   = $clog2(SUM_W + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UPD  = 5'b00010,
        S_ABS  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [CFG_W-1:0]          r_win;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [CFG_W-1:0]          r_fill, n_fill;
    logic [PTR_W-1:0]          r_ptr, n_ptr;
    logic [PTR_W-1:0]          r_slot;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [SAMPLE_WIDTH-1:0] r_old;
    logic [CFG_W-1:0]          r_rem, n_rem;
    logic [SUM_W-1:0]          r_quo, n_quo;
    logic                      r_neg, n_neg;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_average, n_average;

    logic [SAMPLE_WIDTH-1:0]   ring [WINDOW_MAX];

    logic [CFG_W-1:0]          eff_n;
    logic [PTR_W-1:0]          slot;
    logic                      full;
    logic                      in_acc;
    logic                      cfg_acc;
    logic                      out_free;
    logic [CFG_W:0]            trial;
    logic [SAMPLE_WIDTH-1:0]   quo_lo;

    // Effective window: zero reads as one, clamp to ring depth
    always_comb begin
        eff_n = r_win;
        if (r_win == '0) begin
            eff_n = CFG_W'(1);
        end else if (int'(r_win) > WINDOW_MAX) begin
            eff_n = CFG_W'(WINDOW_MAX);
        end
    end

    // Handshakes; a register write goes ahead of a waiting item
    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_valid     = r_out_valid;
    assign o_average   = r_average;
    assign out_free    = !r_out_valid || !i_stall;

    // Slot for this item
    assign slot = (int'(r_ptr) >= int'(eff_n)) ? '0 : r_ptr;
    assign full = (r_fill >= eff_n);

    // Restoring divider step: one quotient bit per cycle
    assign trial  = {r_rem, r_quo[SUM_W-1]} - {1'b0, eff_n};
    assign quo_lo = r_quo[SAMPLE_WIDTH-1:0];

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_average   = r_average;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // Drop the oldest sample once the window is full, add the new one
                n_sum = r_sum + SUM_W'(r_sample)
                      - (full ? SUM_W'(r_old) : SUM_W'(0));
                n_fill = full ? eff_n : r_fill + CFG_W'(1);
                n_ptr  = (int'(r_slot) + 1 >= int'(eff_n)) ? '0 : r_slot + PTR_W'(1);
                if (full || (r_fill + CFG_W'(1) >= eff_n)) begin
                    n_state = S_ABS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ABS: begin
                // Divide magnitudes, fix the sign at the end (truncation toward zero)
                n_neg   = r_sum[SUM_W-1];
                n_quo   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                n_rem   = '0;
                n_cnt   = CNT_W'(SUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!trial[CFG_W]) begin
                    n_rem = trial[CFG_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[CFG_W-2:0], r_quo[SUM_W-1]};
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the quotient until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_average   = r_neg ? -$signed(quo_lo) : $signed(quo_lo);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register write empties the window
        if (cfg_acc) begin
            n_sum  = '0;
            n_fill = '0;
            n_ptr  = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WINDOW_SIZE_RST;
            r_sum       <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (cfg_acc) begin
                r_win <= i_cfg_window_size;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_neg     <= n_neg;
        r_average <= n_average;
        if (in_acc) begin
            r_sample <= i_sample;
            r_slot   <= slot;
        end
    end

    // Sample ring: registered read at accept, write on update
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old <= $signed(ring[slot]);
        end
        if (r_state == S_UPD) begin
            ring[r_slot] <= r_sample;
        end
    end

    // Checks
    `ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= eff_n, "fill count above window")
    `ASSERT_SAME(a_ptr_bound, i_clk, i_rst_n, 1'b1, int'(r_ptr) < int'(eff_n), "pointer out of window")
    `ASSERT_NEXT(a_acc_upd, i_clk, i_rst_n, in_acc, r_state == S_UPD, "item not taken to update")
    `ASSERT_NEXT(a_done_out, i_clk, i_rst_n, (r_state == S_DONE) && out_free, o_valid, "quotient lost")

endmodule
